FILE: design/msp_frame_receiver_macros.svh
// Assertion macros for the frame receiver
`ifndef MSP_FRAME_RECEIVER_MACROS_SVH
`define MSP_FRAME_RECEIVER_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define MSP_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("msp_frame_receiver: check failed");

// next-cycle implication
`define MSP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("msp_frame_receiver: check failed");

`else

`define MSP_ASSERT_IMP(label, clk, rst, ante, cons)
`define MSP_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

FILE: design/msp_rx_pkg.sv
package msp_rx_pkg;

   // header bytes
   localparam logic [7:0] SYNC_DOLLAR = 8'h24;
   localparam logic [7:0] SYNC_M      = 8'h4D;
   localparam logic [7:0] SYNC_ARROW  = 8'h3E;

   // field widths
   localparam int BYTE_W       = 8;
   localparam int SIZE_W       = 7;
   localparam int BYTE_INDEX_W = 6;

   // frame queue: one payload bank per slot
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;
   localparam int QCNT_W      = 2;

   typedef enum logic [2:0] {
      PS_IDLE,
      PS_DOLLAR,
      PS_M,
      PS_ARROW,
      PS_SIZE,
      PS_BODY
   } parse_state_type;

   typedef enum logic {
      PL_IDLE,
      PL_RUN
   } play_state_type;

   // frame descriptor handed from parser to playout
   typedef struct packed {
      logic [BYTE_W-1:0] command;
      logic [SIZE_W-1:0] length;
   } frame_desc_type;

   // queue status seen by both sides
   typedef struct packed {
      logic              full;
      logic              empty;
      logic [QPTR_W-1:0] wr_ptr;
      logic [QPTR_W-1:0] rd_ptr;
   } queue_status_type;

   // payload store write port
   typedef struct packed {
      logic                    en;
      logic [QPTR_W-1:0]       bank;
      logic [BYTE_INDEX_W-1:0] index;
      logic [BYTE_W-1:0]       data;
   } store_write_type;

endpackage

FILE: design/msp_frame_receiver.sv
// Frame receiver: takes one received byte per word and finds frames of the form
// '$' 'M' '>' size command payload checksum. The parser takes a byte every cycle
// unless req_stall holds it. Good frames are queued (two deep, each with its own
// payload bank) and played out one word per payload byte, or a single word with
// has_payload low for an empty frame; each frame is read out of the payload store
// through its single read port. Payload and checksum bytes are held back with
// req_stall only while both banks hold frames still waiting for playout. Frames
// with a bad checksum or a size above BUFFER_DEPTH give no words.
`include "msp_frame_receiver_macros.svh"

module msp_frame_receiver #(
   parameter int BUFFER_DEPTH = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_command,
   output logic [6:0] rsp_payload_size,
   output logic [5:0] rsp_byte_index,
   output logic [7:0] rsp_payload_byte,
   output logic       rsp_has_payload,
   output logic       rsp_last
);
   import msp_rx_pkg::*;

   queue_status_type q_status;
   frame_desc_type   push_desc;
   frame_desc_type   head;
   store_write_type  wr;
   logic             push;
   logic             pop;

   // front: header hunt, checksum, payload capture
   msp_rx_parser #(
      .BUFFER_DEPTH(BUFFER_DEPTH)
   ) u_parser (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_rx_byte (req_rx_byte),
      .req_stall   (req_stall),
      .q_status    (q_status),
      .push        (push),
      .push_desc   (push_desc),
      .wr          (wr)
   );

   // good frames waiting for playout
   msp_rx_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_desc (push_desc),
      .pop       (pop),
      .head      (head),
      .status    (q_status)
   );

   // back: payload store and playout
   msp_rx_player #(
      .BUFFER_DEPTH(BUFFER_DEPTH)
   ) u_player (
      .clock            (clock),
      .reset            (reset),
      .wr               (wr),
      .q_status         (q_status),
      .head             (head),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_command      (rsp_command),
      .rsp_payload_size (rsp_payload_size),
      .rsp_byte_index   (rsp_byte_index),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_has_payload  (rsp_has_payload),
      .rsp_last         (rsp_last)
   );

   // checks
   `MSP_ASSERT_IMP(a_stall_only_when_full, clock, reset, req_stall, q_status.full)
   `MSP_ASSERT_IMP(a_no_write_to_busy_bank, clock, reset, wr.en, !q_status.full)
   `MSP_ASSERT_IMP(a_empty_frame_word, clock, reset, rsp_valid && !rsp_has_payload, rsp_last && (rsp_payload_size == '0))
   `MSP_ASSERT_IMP(a_index_in_frame, clock, reset, rsp_valid && rsp_has_payload, {1'b0, rsp_byte_index} < rsp_payload_size)

endmodule

FILE: design/msp_rx_parser.sv
module msp_rx_parser #(
   parameter int BUFFER_DEPTH = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic [7:0]                    req_rx_byte,
   output logic                          req_stall,
   input  msp_rx_pkg::queue_status_type  q_status,
   output logic                          push,
   output msp_rx_pkg::frame_desc_type    push_desc,
   output msp_rx_pkg::store_write_type   wr
);
   import msp_rx_pkg::*;

   localparam logic [BYTE_W-1:0] DEPTH_LIMIT = BYTE_W'(BUFFER_DEPTH);

   parse_state_type   state_ff, state_in;
   logic [SIZE_W-1:0] length_ff, length_in;
   logic [BYTE_W-1:0] command_ff, command_in;
   logic [BYTE_W-1:0] xor_ff, xor_in;
   logic [SIZE_W-1:0] fill_ff, fill_in;
   logic [BYTE_W-1:0] xor_next;
   logic              accept;

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= PS_IDLE;
         length_ff  <= '0;
         command_ff <= '0;
         xor_ff     <= '0;
         fill_ff    <= '0;
      end else begin
         state_ff   <= state_in;
         length_ff  <= length_in;
         command_ff <= command_in;
         xor_ff     <= xor_in;
         fill_ff    <= fill_in;
      end
   end

   // body words wait while both banks hold frames for playout
   assign req_stall = (state_ff == PS_BODY) && q_status.full;
   assign accept    = req_valid && !req_stall;
   assign xor_next  = xor_ff ^ req_rx_byte;
   assign push_desc = '{command: command_ff, length: length_ff};

   // next state and store writes
   always_comb begin
      state_in   = state_ff;
      length_in  = length_ff;
      command_in = command_ff;
      xor_in     = xor_ff;
      fill_in    = fill_ff;
      push       = 1'b0;
      wr.en      = 1'b0;
      wr.bank    = q_status.wr_ptr;
      wr.index   = fill_ff[BYTE_INDEX_W-1:0];
      wr.data    = req_rx_byte;
      if (accept) begin
         case (state_ff)
            PS_DOLLAR: begin
               state_in = (req_rx_byte == SYNC_M) ? PS_M : PS_IDLE;
            end
            PS_M: begin
               state_in = (req_rx_byte == SYNC_ARROW) ? PS_ARROW : PS_IDLE;
            end
            PS_ARROW: begin
               if (req_rx_byte > DEPTH_LIMIT) begin
                  state_in = PS_IDLE;
               end else begin
                  length_in = req_rx_byte[SIZE_W-1:0];
                  xor_in    = req_rx_byte;
                  state_in  = PS_SIZE;
               end
            end
            PS_SIZE: begin
               command_in = req_rx_byte;
               xor_in     = xor_next;
               fill_in    = '0;
               state_in   = PS_BODY;
            end
            PS_BODY: begin
               xor_in = xor_next;
               if (fill_ff >= length_ff) begin
                  // checksum word: hand over good frames only
                  push     = (xor_next == '0);
                  state_in = PS_IDLE;
               end else begin
                  wr.en   = 1'b1;
                  fill_in = fill_ff + SIZE_W'(1);
               end
            end
            default: begin
               state_in = (req_rx_byte == SYNC_DOLLAR) ? PS_DOLLAR : PS_IDLE;
            end
         endcase
      end
   end

endmodule

FILE: design/msp_rx_queue.sv
module msp_rx_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  msp_rx_pkg::frame_desc_type    push_desc,
   input  logic                          pop,
   output msp_rx_pkg::frame_desc_type    head,
   output msp_rx_pkg::queue_status_type  status
);
   import msp_rx_pkg::*;

   frame_desc_type    slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff, count_in;

   // occupancy
   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   // pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
         count_ff <= count_in;
      end
   end

   // descriptor slots
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_desc;
      end
   end

   assign head          = slot_ff[rd_ptr_ff];
   assign status.full   = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign status.empty  = (count_ff == '0);
   assign status.wr_ptr = wr_ptr_ff;
   assign status.rd_ptr = rd_ptr_ff;

endmodule

FILE: design/msp_rx_player.sv
module msp_rx_player #(
   parameter int BUFFER_DEPTH = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  msp_rx_pkg::store_write_type   wr,
   input  msp_rx_pkg::queue_status_type  q_status,
   input  msp_rx_pkg::frame_desc_type    head,
   output logic                          pop,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [7:0]                    rsp_command,
   output logic [6:0]                    rsp_payload_size,
   output logic [5:0]                    rsp_byte_index,
   output logic [7:0]                    rsp_payload_byte,
   output logic                          rsp_has_payload,
   output logic                          rsp_last
);
   import msp_rx_pkg::*;

   localparam int IDX_W     = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
   localparam int MEM_DEPTH = 2 ** (QPTR_W + IDX_W);

   logic [BYTE_W-1:0] store_mem [MEM_DEPTH];

   play_state_type          state_ff, state_in;
   logic [IDX_W-1:0]        idx_ff, idx_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]       command_ff;
   logic [SIZE_W-1:0]       size_ff;
   logic [BYTE_INDEX_W-1:0] index_ff;
   logic [BYTE_W-1:0]       byte_ff;
   logic                    has_ff;
   logic                    last_ff;
   logic                    out_free;
   logic                    load;
   logic                    is_empty;
   logic                    is_last;

   // payload store, two banks
   always_ff @(posedge clock) begin
      if (wr.en) begin
         store_mem[{wr.bank, wr.index[IDX_W-1:0]}] <= wr.data;
      end
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign load     = (state_ff == PL_RUN) && out_free;
   assign is_empty = (head.length == '0);
   assign is_last  = is_empty || ((SIZE_W'(idx_ff) + SIZE_W'(1)) == head.length);
   assign pop      = load && is_last;

   // playout sequencer
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      rsp_valid_in = load || (rsp_valid_ff && rsp_stall);
      case (state_ff)
         PL_IDLE: begin
            if (!q_status.empty) begin
               state_in = PL_RUN;
               idx_in   = '0;
            end
         end
         PL_RUN: begin
            if (load) begin
               idx_in = idx_ff + IDX_W'(1);
               if (is_last) begin
                  state_in = PL_IDLE;
               end
            end
         end
         default: begin
            state_in = PL_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= PL_IDLE;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // output word, store read lands here
   always_ff @(posedge clock) begin
      if (load) begin
         command_ff <= head.command;
         size_ff    <= head.length;
         index_ff   <= BYTE_INDEX_W'(idx_ff);
         byte_ff    <= is_empty ? '0 : store_mem[{q_status.rd_ptr, idx_ff}];
         has_ff     <= !is_empty;
         last_ff    <= is_last;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_command      = command_ff;
   assign rsp_payload_size = size_ff;
   assign rsp_byte_index   = index_ff;
   assign rsp_payload_byte = byte_ff;
   assign rsp_has_payload  = has_ff;
   assign rsp_last         = last_ff;

endmodule

FILE: verif/msp_frame_receiver_tb.sv
`timescale 1ns / 1ps

module msp_frame_receiver_tb;
   import msp_rx_pkg::*;

   localparam int BUFFER_DEPTH  = 64;
   localparam int SCRIPT_ROWS   = 23;
   localparam int RANDOM_BYTES  = 210;
   localparam int QUIET_AFTER   = SCRIPT_ROWS + 160;
   localparam int DRAIN_AFTER   = SCRIPT_ROWS + 100;
   localparam int SETTLE_CYCLES = 200;
   localparam int NO_ROW        = -1;

   // one result word as the block presents it
   typedef struct packed {
      logic [BYTE_W-1:0]       command;
      logic [SIZE_W-1:0]       payload_size;
      logic [BYTE_INDEX_W-1:0] byte_index;
      logic [BYTE_W-1:0]       payload_byte;
      logic                    has_payload;
      logic                    last;
   } word_type;

   // how a scripted byte is checked
   typedef enum int {
      CHK_MODEL,
      CHK_NONE,
      CHK_ONE
   } row_check_type;

   typedef struct {
      logic [7:0]    rx;
      row_check_type chk;
      word_type      want;
   } stim_row_type;

   localparam word_type NO_WORD = '0;

   logic       clock = 1'b0;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [7:0] req_rx_byte;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_command;
   logic [6:0] rsp_payload_size;
   logic [5:0] rsp_byte_index;
   logic [7:0] rsp_payload_byte;
   logic       rsp_has_payload;
   logic       rsp_last;

   // parser shadow state
   parse_state_type rx_state = PS_IDLE;
   logic [6:0]      frm_len  = '0;
   logic [7:0]      frm_cmd  = '0;
   logic [7:0]      run_xor  = '0;
   logic [6:0]      fill_idx = '0;
   logic [7:0]      pay_store [BUFFER_DEPTH];
   word_type        frame_words [BUFFER_DEPTH];

   word_type     due_words [$];
   stim_row_type script [SCRIPT_ROWS];
   int           cur_row       = NO_ROW;
   int           bytes_sent    = 0;
   int           words_checked = 0;
   int           frames_seen   = 0;
   int           mismatches    = 0;
   int           stall_left    = 0;
   bit           quiet         = 1'b0;

   always #1 clock = ~clock;

   msp_frame_receiver #(
      .BUFFER_DEPTH(BUFFER_DEPTH)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_rx_byte     (req_rx_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_command     (rsp_command),
      .rsp_payload_size(rsp_payload_size),
      .rsp_byte_index  (rsp_byte_index),
      .rsp_payload_byte(rsp_payload_byte),
      .rsp_has_payload (rsp_has_payload),
      .rsp_last        (rsp_last)
   );

   // advance the shadow parser by one byte; returns the number of words played out
   function automatic int parse_byte(input logic [7:0] c);
      int n;
      n = 0;
      case (rx_state)
         PS_DOLLAR: rx_state = (c == SYNC_M) ? PS_M : PS_IDLE;
         PS_M:      rx_state = (c == SYNC_ARROW) ? PS_ARROW : PS_IDLE;
         PS_ARROW: begin
            if (c > BUFFER_DEPTH) begin
               rx_state = PS_IDLE;
            end else begin
               frm_len  = c[6:0];
               run_xor  = c;
               rx_state = PS_SIZE;
            end
         end
         PS_SIZE: begin
            frm_cmd  = c;
            run_xor  = run_xor ^ c;
            fill_idx = '0;
            rx_state = PS_BODY;
         end
         PS_BODY: begin
            run_xor = run_xor ^ c;
            if (fill_idx >= frm_len) begin
               // checksum byte: play out only when the XOR closes to zero
               if (run_xor == 8'h00) begin
                  if (frm_len == 7'd0) begin
                     frame_words[0] = '{frm_cmd, 7'd0, 6'd0, 8'd0, 1'b0, 1'b1};
                     n = 1;
                  end else begin
                     for (int i = 0; i < frm_len; i++) begin
                        frame_words[i] = '{frm_cmd, frm_len, 6'(i), pay_store[i], 1'b1,
                                           1'(i + 1 == frm_len)};
                        n++;
                     end
                  end
               end
               rx_state = PS_IDLE;
            end else begin
               pay_store[fill_idx[5:0]] = c;
               fill_idx = fill_idx + 7'd1;
            end
         end
         default: rx_state = (c == SYNC_DOLLAR) ? PS_DOLLAR : PS_IDLE;
      endcase
      return n;
   endfunction

   function automatic void cmp_field(input string fname, input logic [7:0] want,
                                     input logic [7:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
         mismatches++;
      end
   endfunction

   // byte acceptance, word checking and receiver stalls
   always @(posedge clock) begin
      int       n;
      word_type want;
      if (!reset && req_valid && !req_stall) begin
         n = parse_byte(req_rx_byte);
         if (cur_row != NO_ROW && script[cur_row].chk != CHK_MODEL) begin
            if (script[cur_row].chk == CHK_ONE) due_words.push_back(script[cur_row].want);
         end else begin
            for (int i = 0; i < n; i++) due_words.push_back(frame_words[i]);
         end
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (due_words.size() == 0) begin
            $display("%0t: unexpected word, expected none, actual cmd %0h idx %0d byte %0h",
                     $time, rsp_command, rsp_byte_index, rsp_payload_byte);
            mismatches++;
         end else begin
            want = due_words.pop_front();
            cmp_field("command", want.command, rsp_command);
            cmp_field("payload_size", 8'(want.payload_size), 8'(rsp_payload_size));
            cmp_field("byte_index", 8'(want.byte_index), 8'(rsp_byte_index));
            cmp_field("payload_byte", want.payload_byte, rsp_payload_byte);
            cmp_field("has_payload", 8'(want.has_payload), 8'(rsp_has_payload));
            cmp_field("last", 8'(want.last), 8'(rsp_last));
         end
         words_checked++;
         if (rsp_last === 1'b1) frames_seen++;
      end
      // random stall bursts on rsp_stall
      if (stall_left != 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
         rsp_stall <= 1'b1;
         stall_left = $urandom_range(1, 14) - 1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // offer one byte, wait for it to be taken, then maybe go idle for a while
   task automatic put_byte(input logic [7:0] b, input int row);
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      cur_row     <= row;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      bytes_sent++;
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
   endtask

   // well-formed frame with random content, optionally with a spoilt checksum
   task automatic send_frame(input int size, input bit corrupt);
      logic [7:0] cmd;
      logic [7:0] sum;
      logic [7:0] b;
      cmd = 8'($urandom);
      sum = 8'(size) ^ cmd;
      put_byte(SYNC_DOLLAR, NO_ROW);
      put_byte(SYNC_M, NO_ROW);
      put_byte(SYNC_ARROW, NO_ROW);
      put_byte(8'(size), NO_ROW);
      put_byte(cmd, NO_ROW);
      for (int i = 0; i < size; i++) begin
         b   = 8'($urandom);
         sum = sum ^ b;
         put_byte(b, NO_ROW);
      end
      if (corrupt) sum = sum ^ 8'($urandom_range(1, 255));
      put_byte(sum, NO_ROW);
   endtask

   initial begin
      int         pick;
      int         size;
      logic [7:0] b;
      bit         drained;
      drained = 1'b0;
      script = '{
         // empty frame, command all ones
         '{SYNC_DOLLAR, CHK_NONE, NO_WORD},
         '{SYNC_M,      CHK_NONE, NO_WORD},
         '{SYNC_ARROW,  CHK_NONE, NO_WORD},
         '{8'h00,       CHK_NONE, NO_WORD},
         '{8'hFF,       CHK_NONE, NO_WORD},
         '{8'hFF,       CHK_ONE,  '{8'hFF, 7'd0, 6'd0, 8'h00, 1'b0, 1'b1}},
         // a '$' breaking the header must not restart it
         '{SYNC_DOLLAR, CHK_NONE, NO_WORD},
         '{SYNC_DOLLAR, CHK_NONE, NO_WORD},
         '{SYNC_M,      CHK_NONE, NO_WORD},
         '{SYNC_ARROW,  CHK_NONE, NO_WORD},
         '{8'h00,       CHK_NONE, NO_WORD},
         '{8'h05,       CHK_NONE, NO_WORD},
         '{8'h05,       CHK_NONE, NO_WORD},
         // size one above the buffer depth
         '{SYNC_DOLLAR, CHK_NONE, NO_WORD},
         '{SYNC_M,      CHK_NONE, NO_WORD},
         '{SYNC_ARROW,  CHK_NONE, NO_WORD},
         '{8'h41,       CHK_NONE, NO_WORD},
         // bad checksum on an empty frame
         '{SYNC_DOLLAR, CHK_NONE, NO_WORD},
         '{SYNC_M,      CHK_NONE, NO_WORD},
         '{SYNC_ARROW,  CHK_NONE, NO_WORD},
         '{8'h00,       CHK_NONE, NO_WORD},
         '{8'h12,       CHK_NONE, NO_WORD},
         '{8'h13,       CHK_NONE, NO_WORD}
      };
      req_valid   = 1'b0;
      req_rx_byte = 8'h00;
      reset       = 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (int r = 0; r < SCRIPT_ROWS; r++) put_byte(script[r].rx, r);

      // full-depth frame first, then a random mix
      send_frame(BUFFER_DEPTH, 1'b0);
      while (bytes_sent < SCRIPT_ROWS + RANDOM_BYTES) begin
         if (!drained && bytes_sent >= DRAIN_AFTER) begin
            // hold off until every word due has come out
            req_valid <= 1'b0;
            @(posedge clock);
            while (due_words.size() != 0) @(posedge clock);
            drained = 1'b1;
         end
         quiet = (bytes_sent >= QUIET_AFTER);
         pick  = $urandom_range(0, 99);
         // long frames only while they still fit in the byte budget
         if ($urandom_range(0, 6) == 0 &&
             bytes_sent + BUFFER_DEPTH + 6 <= SCRIPT_ROWS + RANDOM_BYTES) begin
            size = $urandom_range(48, BUFFER_DEPTH);
         end else begin
            size = $urandom_range(0, 8);
         end
         if (pick < 70) begin
            send_frame(size, 1'b0);
         end else if (pick < 80) begin
            send_frame(size, 1'b1);
         end else if (pick < 87) begin
            put_byte(SYNC_DOLLAR, NO_ROW);
            put_byte(SYNC_M, NO_ROW);
            put_byte(SYNC_ARROW, NO_ROW);
            put_byte(8'($urandom_range(BUFFER_DEPTH + 1, 255)), NO_ROW);
         end else if (pick < 94) begin
            // header broken at the second or third byte
            put_byte(SYNC_DOLLAR, NO_ROW);
            b = 8'($urandom);
            if ($urandom_range(0, 1) == 0) begin
               if (b == SYNC_M) b = SYNC_DOLLAR;
            end else begin
               put_byte(SYNC_M, NO_ROW);
               if (b == SYNC_ARROW) b = SYNC_DOLLAR;
            end
            put_byte(b, NO_ROW);
         end else begin
            repeat ($urandom_range(1, 4)) put_byte(8'($urandom), NO_ROW);
         end
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (due_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Summary: %0d bytes sent, %0d words checked over %0d frames played out",
               bytes_sent, words_checked, frames_seen);
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // watchdog
   initial begin
      #3000000;
      $display("Timed out with %0d words still due", due_words.size());
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
